>>> design/ubf_pkg.sv
// ----------------------------------------------------------------------------
// ubf_pkg: shared types for the response fragmenter
// Word formats of both channels, the queued result group and the fixed
// framing constants.
// ----------------------------------------------------------------------------
package ubf_pkg;

	// Initial frame header: command, length high byte, length low byte.
	localparam int unsigned HDR_LEN = 3;

	// Frame length limits and the reset value of the length register.
	localparam logic [9:0] FRAME_LEN_MIN   = 10'd4;
	localparam logic [9:0] FRAME_LEN_MAX   = 10'd512;
	localparam logic [9:0] FRAME_LEN_RESET = 10'd64;

	// Most results one input word can cause.
	localparam int unsigned MAX_RESULTS = 3;

	typedef enum logic {
		OP_START = 1'b0,
		OP_DATA  = 1'b1
	} ubf_opcode_t;

	typedef struct packed {
		ubf_opcode_t opcode;
		logic [7:0]  command;
		logic [15:0] total_length;
		logic [7:0]  data_byte;
	} ubf_in_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_first;
		logic       frame_last;
		logic       message_last;
		logic       error;
	} ubf_out_t;

	// All results of one input word, entry 0 first.
	typedef struct packed {
		logic [1:0]                     cnt;
		ubf_out_t [MAX_RESULTS-1:0]     res;
	} ubf_group_t;

	// Queue status seen by the front and back ends.
	typedef struct packed {
		logic full;
		logic empty;
	} ubf_q_stat_t;

endpackage

>>> design/ubf_front.sv
// ----------------------------------------------------------------------------
// ubf_front: message tracking and result classification
// Accepts input words, keeps the message state and turns each word into a
// group of up to three result words for the queue.
// ----------------------------------------------------------------------------
module ubf_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  ubf_pkg::ubf_in_t     in_data,
	input  logic                 cfg_wr_en,
	input  logic [9:0]           cfg_wr_data,
	input  ubf_pkg::ubf_q_stat_t q_stat,
	output logic                 push,
	output ubf_pkg::ubf_group_t  push_data
);
	import ubf_pkg::*;

	logic        active_q;
	logic [15:0] remaining_q;
	logic [9:0]  fill_q;
	logic [7:0]  seq_q;
	logic [9:0]  max_len_q;

	logic        accept;
	logic [9:0]  limit;
	logic        need_hdr;
	logic [9:0]  fill_base;
	logic [9:0]  fill_inc;
	logic [15:0] remaining_dec;
	logic        msg_last;
	logic        frm_last;
	ubf_out_t    data_res;
	ubf_out_t    zero_res;

	logic        active_d;
	logic [15:0] remaining_d;
	logic [9:0]  fill_d;
	logic [7:0]  seq_d;
	ubf_group_t  grp;

	assign in_stall = q_stat.full;
	assign accept   = in_valid & ~in_stall;

	// Frame length register, clamped into the legal range on use.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= FRAME_LEN_RESET;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	always_comb begin
		if (max_len_q < FRAME_LEN_MIN) begin
			limit = FRAME_LEN_MIN;
		end else if (max_len_q > FRAME_LEN_MAX) begin
			limit = FRAME_LEN_MAX;
		end else begin
			limit = max_len_q;
		end
	end

	// Payload byte path: a full frame first opens a continuation frame.
	assign need_hdr      = (fill_q >= limit);
	assign fill_base     = need_hdr ? 10'd1 : fill_q;
	assign fill_inc      = fill_base + 10'd1;
	assign remaining_dec = remaining_q - 16'd1;
	assign msg_last      = (remaining_dec == 16'd0);
	assign frm_last      = msg_last | (fill_inc >= limit);

	always_comb begin
		zero_res = '0;
		data_res = '0;
		data_res.frame_byte   = in_data.data_byte;
		data_res.frame_last   = frm_last;
		data_res.message_last = msg_last;
	end

	// Next state and result group for the word at the input.
	always_comb begin
		active_d    = active_q;
		remaining_d = remaining_q;
		fill_d      = fill_q;
		seq_d       = seq_q;
		grp         = '0;
		grp.res[0]  = zero_res;
		unique case (in_data.opcode)
			OP_START: begin
				seq_d = 8'd0;
				if (in_data.total_length == 16'd0) begin
					active_d    = 1'b0;
					remaining_d = 16'd0;
					fill_d      = 10'd0;
				end else begin
					active_d    = 1'b1;
					remaining_d = in_data.total_length;
					fill_d      = 10'(HDR_LEN);
					grp.cnt     = 2'(MAX_RESULTS);
					grp.res[0].frame_byte  = in_data.command;
					grp.res[0].frame_first = 1'b1;
					grp.res[1].frame_byte  = in_data.total_length[15:8];
					grp.res[2].frame_byte  = in_data.total_length[7:0];
				end
			end
			OP_DATA: begin
				if (!active_q) begin
					grp.cnt          = 2'd1;
					grp.res[0].error = 1'b1;
				end else begin
					remaining_d = remaining_dec;
					fill_d      = msg_last ? 10'd0 : fill_inc;
					active_d    = ~msg_last;
					if (need_hdr) begin
						seq_d                  = seq_q + 8'd1;
						grp.cnt                = 2'd2;
						grp.res[0].frame_byte  = seq_q;
						grp.res[0].frame_first = 1'b1;
						grp.res[1]             = data_res;
					end else begin
						grp.cnt    = 2'd1;
						grp.res[0] = data_res;
					end
				end
			end
			default: begin
				grp.cnt = 2'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			remaining_q <= 16'd0;
			fill_q      <= 10'd0;
			seq_q       <= 8'd0;
		end else if (accept) begin
			active_q    <= active_d;
			remaining_q <= remaining_d;
			fill_q      <= fill_d;
			seq_q       <= seq_d;
		end
	end

	// An empty message start causes no result and is not queued.
	assign push      = accept & (grp.cnt != 2'd0);
	assign push_data = grp;

endmodule

>>> design/ubf_queue.sv
// ----------------------------------------------------------------------------
// ubf_queue: result group queue
// Short first-in first-out buffer that decouples classification from the
// serialized output.
// ----------------------------------------------------------------------------
module ubf_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ubf_pkg::ubf_group_t  push_data,
	input  logic                 pop,
	output ubf_pkg::ubf_group_t  pop_data,
	output ubf_pkg::ubf_q_stat_t q_stat
);
	import ubf_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	ubf_group_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign q_stat.full  = (count_q == FULL_CNT);
	assign q_stat.empty = (count_q == '0);
	assign pop_data     = mem_q[rd_ptr_q];

	// Storage write.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

>>> design/ubf_back.sv
// ----------------------------------------------------------------------------
// ubf_back: result serializer
// Takes one group at a time from the queue and presents its result words
// one per cycle on the output channel while it is not stalled.
// ----------------------------------------------------------------------------
module ubf_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ubf_pkg::ubf_q_stat_t q_stat,
	input  ubf_pkg::ubf_group_t  pop_data,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output ubf_pkg::ubf_out_t    out_data
);
	import ubf_pkg::*;

	ubf_group_t grp_q;
	logic [1:0] idx_q;
	logic       busy_q;
	logic       out_accept;
	logic       grp_done;

	assign out_valid  = busy_q;
	assign out_data   = grp_q.res[idx_q];
	assign out_accept = busy_q & ~out_stall;
	assign grp_done   = out_accept & ((idx_q + 2'd1) == grp_q.cnt);

	// Fetch the next group when idle or when the last word of this one leaves.
	assign pop = ~q_stat.empty & (~busy_q | grp_done);

	always_ff @(posedge clk) begin
		if (pop) begin
			grp_q <= pop_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (pop) begin
			busy_q <= 1'b1;
			idx_q  <= 2'd0;
		end else if (grp_done) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (out_accept) begin
			idx_q <= idx_q + 2'd1;
		end
	end

endmodule

>>> design/u2f_ble_response_fragmenter.sv
// ----------------------------------------------------------------------------
// u2f_ble_response_fragmenter: response message framing
// Splits a response message into frames with initial and continuation headers.
// ----------------------------------------------------------------------------
// Path: results pass through the result queue and then the back-end group register.
// Throughput: one input word per cycle while the queue is not full; the output port
// moves one result word per cycle while not stalled. A start word yields three result
// words and a payload byte that opens a continuation frame two. The result queue depth
// sets how long input keeps flowing.
// Reset: arst_n clears the message state, the queue and the output; the frame
// length register returns to 64.
module u2f_ble_response_fragmenter #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  ubf_pkg::ubf_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output ubf_pkg::ubf_out_t out_data,
	input  logic              cfg_wr_en,
	input  logic [9:0]        cfg_wr_data
);
	import ubf_pkg::*;

	logic        push;
	logic        pop;
	ubf_group_t  push_data;
	ubf_group_t  pop_data;
	ubf_q_stat_t q_stat;

	// Front end: state tracking and classification.
	ubf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.q_stat      (q_stat),
		.push        (push),
		.push_data   (push_data)
	);

	// Decoupling queue.
	ubf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.q_stat    (q_stat)
	);

	// Back end: one result word per cycle while the output is not stalled.
	ubf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.pop_data  (pop_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

>>> design/ubf_checker.sv
// ----------------------------------------------------------------------------
// ubf_checker: port-level checks for the response fragmenter
// Watches the input and output channels and reset behavior of the top level.
// ----------------------------------------------------------------------------
module ubf_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input ubf_pkg::ubf_in_t  in_data,
	input logic              out_valid,
	input logic              out_stall,
	input ubf_pkg::ubf_out_t out_data
);
	import ubf_pkg::*;

	// A stalled input word is held by the sender.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_data))
		else $error("input word changed while stalled");

	// A stalled output word stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output word changed while stalled");

	// An error word carries no byte and no framing flags.
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.error |->
			out_data.frame_byte == 8'd0 && !out_data.frame_first &&
			!out_data.frame_last && !out_data.message_last)
		else $error("error word with framing content");

	// The end of a message also ends its frame, and never opens one.
	a_msg_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.message_last |-> out_data.frame_last && !out_data.frame_first)
		else $error("message end without frame end");

	// Nothing is offered once reset has been seen at a clock edge.
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("output valid during reset");

endmodule

bind u2f_ble_response_fragmenter ubf_checker u_ubf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

>>> verif/u2f_ble_response_fragmenter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2f_ble_response_fragmenter_tb: self-checking bench for the response fragmenter
// Sends start and payload words under random sender and receiver idling. Every
// accepted word is run through a local framing predictor, and each result word
// is compared field by field with the oldest predicted byte.
// ----------------------------------------------------------------------------
module u2f_ble_response_fragmenter_tb;
	import ubf_pkg::*;

	localparam int TAIL_CYCLES  = 8;
	localparam int HOLD_CYCLES  = 300;
	localparam int STUCK_LIMIT  = 3000;
	localparam int REPORT_LIMIT = 10;

	logic       clk;
	logic       arst_n      = 1'b0;
	logic       in_valid    = 1'b0;
	logic       in_stall;
	ubf_in_t    in_data     = '0;
	logic       out_valid;
	logic       out_stall   = 1'b0;
	ubf_out_t   out_data;
	logic       cfg_wr_en   = 1'b0;
	logic [9:0] cfg_wr_data = '0;

	// Words waiting to be offered and frame bytes the block still owes us.
	ubf_in_t  words_to_send[$];
	ubf_out_t frame_words_due[$];

	// Local copy of the framing state and the frame length register.
	logic [9:0]  frame_len_reg = FRAME_LEN_RESET;
	logic        msg_active    = 1'b0;
	logic [15:0] bytes_left    = '0;
	logic [9:0]  frame_fill    = '0;
	logic [7:0]  seq_num       = '0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_asked    = 0;
	int hold_taken    = 0;
	int hold_left     = 0;
	int stuck_cycles  = 0;
	int mismatch_cnt  = 0;
	int words_in      = 0;
	int results_out   = 0;
	int stray_cnt     = 0;
	int cont_cnt      = 0;
	int cfg_writes    = 0;

	u2f_ble_response_fragmenter DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// 100 MHz clock, starting low so the first rising edge falls inside reset.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// The block treats out-of-range frame lengths as the nearest limit.
	function automatic logic [9:0] eff_frame_len(input logic [9:0] v);
		if (v < FRAME_LEN_MIN) return FRAME_LEN_MIN;
		if (v > FRAME_LEN_MAX) return FRAME_LEN_MAX;
		return v;
	endfunction

	function automatic void expect_byte(input logic [7:0] b, input logic first,
			input logic flast, input logic mlast, input logic err);
		ubf_out_t r;
		r.frame_byte   = b;
		r.frame_first  = first;
		r.frame_last   = flast;
		r.message_last = mlast;
		r.error        = err;
		frame_words_due.push_back(r);
	endfunction

	// Works out the frame bytes that one accepted word produces.
	function automatic void frame_predict(input ubf_in_t w);
		logic [9:0] lim;
		logic       mlast;
		logic       flast;
		lim = eff_frame_len(frame_len_reg);
		if (w.opcode == OP_START) begin
			seq_num = '0;
			if (w.total_length == 16'd0) begin
				msg_active = 1'b0;
				bytes_left = '0;
				frame_fill = '0;
			end else begin
				msg_active = 1'b1;
				bytes_left = w.total_length;
				frame_fill = 10'(HDR_LEN);
				expect_byte(w.command, 1'b1, 1'b0, 1'b0, 1'b0);
				expect_byte(w.total_length[15:8], 1'b0, 1'b0, 1'b0, 1'b0);
				expect_byte(w.total_length[7:0], 1'b0, 1'b0, 1'b0, 1'b0);
			end
		end else if (!msg_active) begin
			// A payload byte with no message open is dropped and flagged.
			expect_byte(8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
			stray_cnt++;
		end else begin
			if (frame_fill >= lim) begin
				expect_byte(seq_num, 1'b1, 1'b0, 1'b0, 1'b0);
				seq_num    = seq_num + 8'd1;
				frame_fill = 10'd1;
				cont_cnt++;
			end
			frame_fill = frame_fill + 10'd1;
			bytes_left = bytes_left - 16'd1;
			mlast      = (bytes_left == 16'd0);
			flast      = mlast || (frame_fill >= lim);
			expect_byte(w.data_byte, 1'b0, flast, mlast, 1'b0);
			if (mlast) begin
				msg_active = 1'b0;
				frame_fill = '0;
			end
		end
	endfunction

	// Sender: offers queued words, holds a stalled word steady.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				frame_predict(in_data);
				words_in <= words_in + 1;
			end
			if (!in_valid || !in_stall) begin
				if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data  <= words_to_send.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks every accepted result word and drives the stall.
	always @(posedge clk or negedge arst_n) begin
		ubf_out_t want;
		if (!arst_n) begin
			out_stall  <= 1'b0;
			hold_left  <= 0;
			hold_taken <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				results_out <= results_out + 1;
				if (frame_words_due.size() == 0) begin
					if (mismatch_cnt < REPORT_LIMIT)
						$display("Unexpected word: byte %02h first %0b last %0b mlast %0b err %0b",
							out_data.frame_byte, out_data.frame_first, out_data.frame_last,
							out_data.message_last, out_data.error);
					mismatch_cnt <= mismatch_cnt + 1;
				end else begin
					want = frame_words_due.pop_front();
					if (out_data.frame_byte !== want.frame_byte ||
							out_data.frame_first !== want.frame_first ||
							out_data.frame_last !== want.frame_last ||
							out_data.message_last !== want.message_last ||
							out_data.error !== want.error) begin
						if (mismatch_cnt < REPORT_LIMIT)
							$display("Mismatch at word %0d: expected %02h %0b%0b%0b%0b, got %02h %0b%0b%0b%0b",
								results_out, want.frame_byte, want.frame_first, want.frame_last,
								want.message_last, want.error, out_data.frame_byte,
								out_data.frame_first, out_data.frame_last,
								out_data.message_last, out_data.error);
						mismatch_cnt <= mismatch_cnt + 1;
					end
				end
			end
			// A requested long hold takes priority over random stalls.
			if (hold_taken != hold_asked) begin
				hold_taken <= hold_asked;
				hold_left  <= HOLD_CYCLES;
				out_stall  <= 1'b1;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// Watchdog: ends the run if no word moves on either side for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("Timeout: no word moved for %0d cycles", STUCK_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic write_frame_len(input logic [9:0] v);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en     <= 1'b0;
		frame_len_reg  = v;
		cfg_writes++;
	endtask

	// Waits until every queued word is sent and every frame byte has arrived.
	task automatic wait_drained();
		while (words_to_send.size() != 0 || in_valid || frame_words_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// Unused fields of each word are random so that all their bits toggle.
	function automatic void push_start(input logic [7:0] cmd, input logic [15:0] len);
		ubf_in_t w;
		w.opcode       = OP_START;
		w.command      = cmd;
		w.total_length = len;
		w.data_byte    = 8'($urandom);
		words_to_send.push_back(w);
	endfunction

	function automatic void push_byte(input logic [7:0] b);
		ubf_in_t w;
		w.opcode       = OP_DATA;
		w.command      = 8'($urandom);
		w.total_length = 16'($urandom);
		w.data_byte    = b;
		words_to_send.push_back(w);
	endfunction

	function automatic void push_message(input logic [15:0] len, input int nbytes);
		push_start(8'($urandom), len);
		for (int i = 0; i < nbytes; i++)
			push_byte(8'($urandom));
	endfunction

	// Message lengths: mostly short, some placed right at frame boundaries.
	function automatic int msg_len(input int len_cap);
		int lim;
		int pick;
		int b;
		lim  = int'(eff_frame_len(frame_len_reg));
		pick = $urandom_range(99);
		if (pick < 40) return $urandom_range(8, 1);
		if (pick < 55) return $urandom_range((len_cap < 40) ? len_cap : 40, 9);
		b = (lim - 3) + $urandom_range(2) * (lim - 1) + $urandom_range(2) - 1;
		if (b < 1 || b > len_cap) return $urandom_range(8, 1);
		return b;
	endfunction

	// Mostly complete messages, with stray bytes, empty starts and
	// messages cut short by the next start mixed in.
	task automatic queue_traffic(input int n_words, input int len_cap);
		int made;
		int pick;
		int len;
		int sent;
		made = 0;
		while (made < n_words) begin
			pick = $urandom_range(99);
			if (pick < 6) begin
				push_byte(8'($urandom));
				made += 1;
			end else if (pick < 10) begin
				push_start(8'($urandom), 16'd0);
				made += 1;
			end else if (pick < 20) begin
				len  = $urandom_range(65535, 2);
				sent = $urandom_range(5, 0);
				push_message(16'(len), sent);
				made += 1 + sent;
			end else begin
				len = msg_len(len_cap);
				push_message(16'(len), len);
				made += 1 + len;
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed words at the smallest frame length.
		send_idle_pct = 22;
		recv_idle_pct = 65;
		write_frame_len(10'd4);
		push_byte(8'hFF);
		push_start(8'h00, 16'h0000);
		push_byte(8'h00);
		push_start(8'hFF, 16'hFFFF);
		push_byte(8'hA5);
		push_byte(8'h5A);
		push_byte(8'h00);
		push_byte(8'hFF);
		// A new start abandons the long message in progress.
		push_start(8'h83, 16'h0003);
		push_byte(8'h01);
		push_byte(8'h02);
		push_byte(8'h03);
		push_byte(8'h11);
		push_start(8'h81, 16'h0001);
		push_byte(8'h22);
		push_start(8'h82, 16'h0004);
		push_byte(8'h41);
		push_byte(8'h42);
		push_byte(8'h43);
		push_byte(8'h44);
		// An empty start also closes an open message.
		push_start(8'h84, 16'h0100);
		push_start(8'h85, 16'h0000);
		push_byte(8'h33);
		wait_drained();

		// Sender idles lightly, receiver heavily.
		write_frame_len(10'd5);
		queue_traffic(25, 20);
		wait_drained();
		write_frame_len(10'd0);
		queue_traffic(20, 20);
		wait_drained();

		// Sender idles heavily, receiver lightly; largest frame lengths.
		send_idle_pct = 65;
		recv_idle_pct = 22;
		write_frame_len(10'd1023);
		queue_traffic(25, 20);
		wait_drained();
		write_frame_len(10'd512);
		queue_traffic(20, 20);
		wait_drained();

		// No idling on either side.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_frame_len(10'($urandom_range(40, 6)));
		queue_traffic(30, 30);
		wait_drained();

		// Long receiver hold while the sender keeps offering words.
		write_frame_len(10'd64);
		hold_asked <= hold_asked + 1;
		queue_traffic(45, 30);
		wait_drained();

		$display("Sent %0d words under %0d frame length settings; received %0d result words.",
			words_in, cfg_writes, results_out);
		$display("Covered %0d stray payload bytes and %0d continuation headers.",
			stray_cnt, cont_cnt);
		if (mismatch_cnt == 0 && frame_words_due.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches, %0d expected words never arrived",
				mismatch_cnt, frame_words_due.size());
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

>>> files.f
design/ubf_pkg.sv
design/ubf_front.sv
design/ubf_queue.sv
design/ubf_back.sv
design/u2f_ble_response_fragmenter.sv
design/ubf_checker.sv
verif/u2f_ble_response_fragmenter_tb.sv
